@@ rtl/fwo_pkg.sv @@
// Package for the FM frequency write orderer: beat and emit types, address constants.
// Used by fwo_shadow, fwo_out_queue and fm_frequency_write_orderer.
package fwo_pkg;

    localparam int unsigned SHADOW_DEPTH = 32;
    localparam int unsigned SHADOW_AW    = $clog2(SHADOW_DEPTH);
    localparam int unsigned LATCH_DEPTH  = 2;

    // Frequency registers live at 0xA0-0xAF.
    localparam logic [3:0] FREQ_HI_NIB   = 4'hA;
    // Address bit 2 marks the high half (latch), bit 3 picks the latch shadow.
    localparam int unsigned LATCH_SEL_BIT  = 3;
    localparam logic [7:0]  PARTNER_FLIP   = 8'h04;
    localparam logic [SHADOW_AW-1:0] PARTNER_FLIP_IDX = SHADOW_AW'(4);

    typedef struct packed {
        logic       port;
        logic [7:0] addr;
        logic [7:0] value;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic  dual;     // two beats emitted for this item
        t_beat first;
        t_beat second;
    } t_emit;

endpackage

@@ rtl/fwo_shadow.sv @@
// Frequency and latch shadows plus the decision of which beats one write emits.
// Depends on fwo_pkg for t_beat, t_emit and address constants.
module fwo_shadow (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic                i_port,
    input  logic [7:0]          i_addr,
    input  logic [7:0]          i_value,
    input  logic                i_partner,
    output logic                o_is_freq,
    output fwo_pkg::t_emit      o_emit
);

    logic [7:0] r_freq  [fwo_pkg::SHADOW_DEPTH];
    logic [7:0] r_latch [fwo_pkg::LATCH_DEPTH];

    logic [fwo_pkg::SHADOW_AW-1:0] idx;
    logic [fwo_pkg::SHADOW_AW-1:0] pidx;
    logic                          lid;
    logic                          is_latch;
    logic [7:0]                    other;
    logic                          stale;
    logic [7:0]                    n_latch_val;
    logic [7:0]                    partner_addr;

    assign o_is_freq    = (i_addr[7:4] == fwo_pkg::FREQ_HI_NIB);
    assign idx          = {i_port, i_addr[3:0]};
    assign pidx         = idx ^ fwo_pkg::PARTNER_FLIP_IDX;
    assign lid          = i_addr[fwo_pkg::LATCH_SEL_BIT];
    assign is_latch     = |(i_addr & fwo_pkg::PARTNER_FLIP);
    assign other        = r_freq[pidx];
    assign stale        = (r_latch[lid] != other);
    assign partner_addr = i_addr ^ fwo_pkg::PARTNER_FLIP;
    assign n_latch_val  = is_latch ? i_value : other;

    always_comb begin
        o_emit.dual          = 1'b0;
        o_emit.first.port    = i_port;
        o_emit.first.addr    = i_addr;
        o_emit.first.value   = i_value;
        o_emit.first.last    = 1'b1;
        o_emit.second.port   = i_port;
        o_emit.second.addr   = i_addr;
        o_emit.second.value  = i_value;
        o_emit.second.last   = 1'b1;
        if (o_is_freq) begin
            if (is_latch) begin
                // Resend the shadowed low half unless the partner follows.
                o_emit.dual         = ~i_partner;
                o_emit.first.last   = i_partner;
                o_emit.second.addr  = partner_addr;
                o_emit.second.value = other;
            end else if (stale) begin
                // Refresh the high half before the low-half write.
                o_emit.dual         = 1'b1;
                o_emit.first.addr   = partner_addr;
                o_emit.first.value  = other;
                o_emit.first.last   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fwo_pkg::SHADOW_DEPTH; i++) begin
                r_freq[i] <= '0;
            end
            for (int i = 0; i < fwo_pkg::LATCH_DEPTH; i++) begin
                r_latch[i] <= '0;
            end
        end else if (i_go && o_is_freq) begin
            r_freq[idx] <= i_value;
            if (is_latch || stale) begin
                r_latch[lid] <= n_latch_val;
            end
        end
    end

endmodule

@@ rtl/fwo_out_queue.sv @@
// Two-entry output queue that takes one or two beats per push and drains one per cycle while i_ready is high.
// Depends on fwo_pkg for t_beat and t_emit.
module fwo_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fwo_pkg::t_emit  i_emit,
    output logic            o_can_one,
    output logic            o_can_two,
    output logic            o_valid,
    input  logic            i_ready,
    output fwo_pkg::t_beat  o_beat
);

    fwo_pkg::t_beat r_q [2];
    logic [1:0]     r_cnt;

    fwo_pkg::t_beat n_q [2];
    logic [1:0]     n_cnt;
    logic [1:0]     cnt_p;
    logic           pop;

    assign o_valid   = (r_cnt != 2'd0);
    assign o_beat    = r_q[0];
    assign pop       = o_valid && i_ready;
    assign cnt_p     = r_cnt - {1'b0, pop};
    assign o_can_one = (cnt_p != 2'd2);
    assign o_can_two = (cnt_p == 2'd0);

    always_comb begin
        // Advance the head on a pop, then append behind what remains.
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = cnt_p;
        if (i_push) begin
            if (cnt_p == 2'd0) begin
                n_q[0] = i_emit.first;
                n_q[1] = i_emit.second;
            end else begin
                n_q[1] = i_emit.first;
            end
            n_cnt = cnt_p + 2'd1 + {1'b0, i_emit.dual};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

@@ rtl/fm_frequency_write_orderer.sv @@
// FM frequency write orderer: reorders frequency register writes into coherent pairs.
// Path from input beat to first output beat: input register, then output queue.
// Throughput: the output queue drains a single beat per cycle while i_out_ready is high;
// a held write is taken only when the queue has room for all of its beats.
// Reset: synchronous active-low; clears both shadows to zero and empties all stages.
// Depends on fwo_pkg, fwo_shadow and fwo_out_queue.
module fm_frequency_write_orderer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_chip_port,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_value,
    input  logic       i_next_is_partner,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_out_port,
    output logic [7:0] o_out_addr,
    output logic [7:0] o_out_value,
    output logic       o_last
);

    logic       r_in_vld;
    logic       r_in_port;
    logic [7:0] r_in_addr;
    logic [7:0] r_in_value;
    logic       r_in_partner;

    logic           go;
    logic           is_freq;
    logic           can_one;
    logic           can_two;
    fwo_pkg::t_emit emit;
    fwo_pkg::t_beat out_beat;

    // Process the held write only when the queue can take all of its beats.
    assign go         = r_in_vld && (emit.dual ? can_two : can_one);
    assign o_in_ready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_port    <= i_chip_port;
            r_in_addr    <= i_reg_addr;
            r_in_value   <= i_write_value;
            r_in_partner <= i_next_is_partner;
        end
    end

    fwo_shadow u_shadow (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_port    (r_in_port),
        .i_addr    (r_in_addr),
        .i_value   (r_in_value),
        .i_partner (r_in_partner),
        .o_is_freq (is_freq),
        .o_emit    (emit)
    );

    fwo_out_queue u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (go),
        .i_emit    (emit),
        .o_can_one (can_one),
        .o_can_two (can_two),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_beat    (out_beat)
    );

    assign o_out_port  = out_beat.port;
    assign o_out_addr  = out_beat.addr;
    assign o_out_value = out_beat.value;
    assign o_last      = out_beat.last;

`ifndef SYNTH
    a_passthru_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && !is_freq |-> !emit.dual)
        else $error("non-frequency write emitted two beats");

    a_dual_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && emit.dual |-> !emit.first.last && emit.second.last)
        else $error("last flag misplaced on a two-beat emit");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && !emit.dual |-> emit.first.last)
        else $error("single-beat emit without last");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !go |=> r_in_vld && $stable(r_in_addr) && $stable(r_in_value))
        else $error("held write lost while the queue was full");
`endif

endmodule
